// ===== hdl/rtrcc_pkg.sv =====
// package for the region table range coverage check
// types, command codes and fsm states shared by the core and its submodules
`default_nettype none

package rtrcc_pkg;

   typedef logic [1:0] command_type;

   localparam command_type CMD_CLEAR  = 2'd0;
   localparam command_type CMD_APPEND = 2'd1;
   localparam command_type CMD_QUERY  = 2'd2;

   // region type code for usable memory
   localparam logic [31:0] KIND_USABLE = 32'd1;

   // which end of the range the first overlapping region touches
   typedef logic [1:0] fit_type;

   localparam fit_type FIT_NONE = 2'b00;
   localparam fit_type FIT_LOW  = 2'b01;
   localparam fit_type FIT_HIGH = 2'b10;
   localparam fit_type FIT_BOTH = 2'b11;

   // region end is kept exact, one bit wider than the address
   typedef struct packed {
      logic        usable;
      logic [64:0] top_addr;
      logic [63:0] base;
   } entry_type;

   typedef struct packed {
      logic init;
      logic valid;
   } scan_ctl_type;

   typedef struct packed {
      logic        span;
      fit_type     fit;
      logic [63:0] trim;
   } scan_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_SCAN,
      ST_DECIDE
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/rtrcc_region_mem.sv =====
// region table storage: one write port, one read port, registered read data
// depends on rtrcc_pkg for the entry layout
`default_nettype none

module rtrcc_region_mem
   import rtrcc_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/rtrcc_scan_unit.sv =====
// one pass over the table: tests each entry read back against the range
// and keeps the spanning flag and the first overlapping region; uses rtrcc_pkg
`default_nettype none

module rtrcc_scan_unit
   import rtrcc_pkg::*;
(
   input  wire logic         clock,
   input  wire scan_ctl_type ctl,
   input  wire entry_type    entry,
   input  wire logic [63:0]  lo,
   input  wire logic [63:0]  hi,
   output scan_res_type      res
);

   logic        span_ff, span_in;
   fit_type     fit_ff, fit_in;
   logic [63:0] trim_ff, trim_in;

   logic    hit_low;
   logic    hit_high;
   logic    hit_span;
   fit_type fit_now;

   always_comb begin
      hit_span = entry.usable && (entry.base <= lo) && (entry.top_addr >= {1'b0, hi});
      hit_low  = entry.usable && (entry.base <= lo) && (entry.top_addr > {1'b0, lo});
      hit_high = entry.usable && (entry.top_addr >= {1'b0, hi}) && (entry.base < hi);
      fit_now  = {hit_high, hit_low};
   end

   always_comb begin
      span_in = span_ff;
      fit_in  = fit_ff;
      trim_in = trim_ff;
      if (ctl.init) begin
         span_in = 1'b0;
         fit_in  = FIT_NONE;
      end else if (ctl.valid) begin
         span_in = span_ff | hit_span;
         // only the first overlapping region counts
         if (fit_ff == FIT_NONE && fit_now != FIT_NONE) begin
            fit_in  = fit_now;
            trim_in = hit_low ? entry.top_addr[63:0] : entry.base;
         end
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
      fit_ff  <= fit_in;
      trim_ff <= trim_in;
   end

   assign res = '{span: span_ff, fit: fit_ff, trim: trim_ff};

endmodule

`default_nettype wire

// ===== hdl/region_table_range_coverage_check_core.sv =====
// top level of the region table range coverage check
// uses rtrcc_pkg, rtrcc_region_mem and rtrcc_scan_unit
//
//   channel   handshake            payload
//   request   start / busy         req_command, req_region_*, req_range_*
//   response  rsp_strobe (1 cyc)   rsp_covered, rsp_status
//
// clear, append and the unused code finish in the accept cycle; the response
// strobe is registered and comes in the next cycle, and busy stays low.
// a query holds busy for R scan rounds, plus a final ST_ROUND visit when it stops
// on an empty range, n = regions stored, R <= n + 1; the strobe follows busy.
// each round walks the single table read port one entry a cycle.
// reset clears the region count, the fsm and the strobe; table contents stay.
// the response cannot be stalled; a new word may be started while it shows.
`default_nettype none

module region_table_range_coverage_check_core
   import rtrcc_pkg::*;
#(
   parameter int MAX_REGIONS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [63:0] req_region_base,
   input  wire logic [63:0] req_region_length,
   input  wire logic [31:0] req_region_kind,
   input  wire logic [63:0] req_range_low,
   input  wire logic [63:0] req_range_high,
   output logic             rsp_strobe,
   output logic             rsp_covered,
   output logic             rsp_status
);

   localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int RW = $clog2(2 * MAX_REGIONS + 3);
   localparam logic [CW-1:0] COUNT_FULL  = CW'(MAX_REGIONS);
   localparam logic [RW-1:0] ROUND_LIMIT = RW'(2 * MAX_REGIONS + 2);

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [RW-1:0] round_ff, round_in;
   logic [63:0]   lo_ff, lo_in;
   logic [63:0]   hi_ff, hi_in;
   logic          rd_valid_ff;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic          rsp_covered_ff, rsp_covered_in;
   logic          rsp_status_ff, rsp_status_in;

   logic         accept;
   logic         full;
   logic         issue;
   logic         finish;
   logic         fin_cov;
   logic         trim;
   logic         scan_init;
   logic         wr_en;
   entry_type    wr_entry;
   entry_type    rd_entry;
   scan_ctl_type scan_ctl;
   scan_res_type scan_res;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign full   = (count_ff == COUNT_FULL);
   assign wr_en  = accept && (req_command == CMD_APPEND) && !full;

   // end address computed once at append time, so the scan only compares
   assign wr_entry = '{
      usable:   (req_region_kind == KIND_USABLE),
      top_addr: {1'b0, req_region_base} + {1'b0, req_region_length},
      base:     req_region_base
   };

   rtrcc_region_mem #(
      .DEPTH (MAX_REGIONS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_entry)
   );

   assign scan_ctl = '{init: scan_init, valid: rd_valid_ff};

   rtrcc_scan_unit u_scan (
      .clock (clock),
      .ctl   (scan_ctl),
      .entry (rd_entry),
      .lo    (lo_ff),
      .hi    (hi_ff),
      .res   (scan_res)
   );

   // fsm outputs
   always_comb begin
      issue     = 1'b0;
      scan_init = 1'b0;
      finish    = 1'b0;
      fin_cov   = 1'b0;
      trim      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
         end
         ST_ROUND: begin
            if (lo_ff >= hi_ff || round_ff == ROUND_LIMIT) begin
               finish = 1'b1;
            end else begin
               scan_init = 1'b1;
            end
         end
         ST_SCAN: begin
            issue = (idx_ff < count_ff);
         end
         ST_DECIDE: begin
            if (scan_res.span || scan_res.fit == FIT_BOTH) begin
               finish  = 1'b1;
               fin_cov = 1'b1;
            end else if (scan_res.fit == FIT_NONE) begin
               finish = 1'b1;
            end else begin
               trim = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // fsm next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_QUERY) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = finish ? ST_IDLE : ST_SCAN;
         end
         ST_SCAN: begin
            // last read data is being taken in this cycle
            if (!issue) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = trim ? ST_ROUND : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      count_in       = count_ff;
      idx_in         = idx_ff;
      round_in       = round_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      rsp_strobe_in  = 1'b0;
      rsp_covered_in = 1'b0;
      rsp_status_in  = 1'b0;
      if (accept) begin
         case (req_command)
            CMD_CLEAR: begin
               count_in      = '0;
               rsp_strobe_in = 1'b1;
            end
            CMD_APPEND: begin
               rsp_strobe_in = 1'b1;
               if (full) begin
                  rsp_status_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            CMD_QUERY: begin
               lo_in    = req_range_low;
               hi_in    = req_range_high;
               round_in = '0;
            end
            default: begin
               rsp_strobe_in = 1'b1;
            end
         endcase
      end
      if (finish) begin
         rsp_strobe_in  = 1'b1;
         rsp_covered_in = fin_cov;
      end
      if (scan_init) begin
         idx_in = '0;
      end else if (issue) begin
         idx_in = idx_ff + CW'(1);
      end
      if (trim) begin
         round_in = round_ff + RW'(1);
         if (scan_res.fit == FIT_LOW) begin
            lo_in = scan_res.trim;
         end else begin
            hi_in = scan_res.trim;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_valid_ff   <= issue;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      round_ff       <= round_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      rsp_covered_ff <= rsp_covered_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_covered = rsp_covered_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

`default_nettype wire
